[hdl/stcw_pkg.sv]
// Shared constants, codes and controller/datapath types for the scrolling text console.
package stcw_pkg;

   // Geometry of the cell store
   localparam int MAX_WIDTH = 64;
   localparam int MAX_LINES = 8;
   localparam int TAB_STOP  = 8;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_LINES);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int TAB_W    = $clog2(TAB_STOP);

   // Field and register widths
   localparam int CHAR_W      = 8;
   localparam int CURSOR_W    = 7;
   localparam int LINES_W     = 4;
   localparam int READ_LINE_W = 3;
   localparam int READ_COL_W  = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // Register reset values
   localparam logic [CURSOR_W-1:0] LINE_WIDTH_RESET   = CURSOR_W'(64);
   localparam logic [LINES_W-1:0]  SCROLL_LINES_RESET = LINES_W'(8);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_LINES = 1'b1;

   // Command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h08;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      CLS_TAB,
      CLS_LF,
      CLS_CR,
      CLS_SPACE,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_SWEEP,
      ST_WRITE,
      ST_TAB,
      ST_RESULT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic load_item;
      logic mem_read;
      logic do_lf;
      logic scroll;
      logic sweep_start;
      logic sweep_step;
      logic put_char;
      logic tab_step;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic           is_read;
      char_class_type char_class;
      logic           need_scroll;
      logic           cell_in_line;
      logic           row_valid;
      logic           sweep_last;
      logic           tab_last;
      logic           rsp_free;
   } status_type;

endpackage

[hdl/stcw_if.sv]
// Request and response channel interfaces of the scrolling text console.
interface stcw_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic [stcw_pkg::CHAR_W-1:0]           char_code;
   logic [stcw_pkg::READ_LINE_W-1:0]      read_line;
   logic [stcw_pkg::READ_COL_W-1:0]       read_column;

   modport source (output valid, command, char_code, read_line, read_column, input ready);
   modport sink   (input valid, command, char_code, read_line, read_column, output ready);
endinterface

interface stcw_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [stcw_pkg::CHAR_W-1:0]           cell_char;
   logic [stcw_pkg::CURSOR_W-1:0]         cursor_column;
   logic                                  newline_pending;

   modport source (output valid, cell_char, cursor_column, newline_pending, input ready);
   modport sink   (input valid, cell_char, cursor_column, newline_pending, output ready);
endinterface

[hdl/stcw_ctrl.sv]
// Sequencer of the scrolling text console: decodes an item and steps the datapath.
module stcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  stcw_pkg::status_type   status,
   output stcw_pkg::cmd_type      cmd
);

   stcw_pkg::state_type state_ff;
   stcw_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stcw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         stcw_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = stcw_pkg::ST_DECODE;
            end
         end
         stcw_pkg::ST_DECODE: begin
            if (status.is_read) begin
               cmd.mem_read = 1'b1;
               state_in     = stcw_pkg::ST_RESULT;
            end else if (status.char_class == stcw_pkg::CLS_CR) begin
               state_in = stcw_pkg::ST_RESULT;
            end else if (status.char_class == stcw_pkg::CLS_LF) begin
               cmd.do_lf = 1'b1;
               state_in  = stcw_pkg::ST_RESULT;
            end else begin
               cmd.scroll = status.need_scroll;
               state_in   = stcw_pkg::ST_CHECK;
            end
         end
         stcw_pkg::ST_CHECK: begin
            // a row emptied by a scroll is zeroed before its first write
            if (status.cell_in_line && !status.row_valid) begin
               cmd.sweep_start = 1'b1;
               state_in        = stcw_pkg::ST_SWEEP;
            end else if (status.char_class == stcw_pkg::CLS_TAB) begin
               state_in = stcw_pkg::ST_TAB;
            end else begin
               state_in = stcw_pkg::ST_WRITE;
            end
         end
         stcw_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = (status.char_class == stcw_pkg::CLS_TAB) ?
                          stcw_pkg::ST_TAB : stcw_pkg::ST_WRITE;
            end
         end
         stcw_pkg::ST_WRITE: begin
            cmd.put_char = 1'b1;
            state_in     = stcw_pkg::ST_RESULT;
         end
         stcw_pkg::ST_TAB: begin
            cmd.tab_step = 1'b1;
            if (status.tab_last) begin
               state_in = stcw_pkg::ST_RESULT;
            end
         end
         stcw_pkg::ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = stcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stcw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/stcw_dpath.sv]
// Datapath of the scrolling text console: registers, cursor, line ring and cell memory.
module stcw_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stcw_pkg::cmd_type                     cmd,
   output stcw_pkg::status_type                  status,
   input  logic                                  csr_wr_en,
   input  logic [stcw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [stcw_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                                  item_command,
   input  logic [stcw_pkg::CHAR_W-1:0]           item_char_code,
   input  logic [stcw_pkg::READ_LINE_W-1:0]      item_read_line,
   input  logic [stcw_pkg::READ_COL_W-1:0]       item_read_column,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [stcw_pkg::CHAR_W-1:0]           rsp_cell_char,
   output logic [stcw_pkg::CURSOR_W-1:0]         rsp_cursor_column,
   output logic                                  rsp_newline_pending
);

   localparam int DEPTH = stcw_pkg::MAX_WIDTH * stcw_pkg::MAX_LINES;

   // Control state
   logic [stcw_pkg::CURSOR_W-1:0]   line_width_ff, line_width_in;
   logic [stcw_pkg::LINES_W-1:0]    scroll_lines_ff, scroll_lines_in;
   logic [stcw_pkg::ROW_W-1:0]      top_ff, top_in;
   logic [stcw_pkg::CURSOR_W-1:0]   cursor_ff, cursor_in;
   logic                            pending_ff, pending_in;
   logic [stcw_pkg::MAX_LINES-1:0]  row_valid_ff, row_valid_in;
   logic [stcw_pkg::COL_W-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Item and result payload
   logic                                  command_ff;
   logic [stcw_pkg::CHAR_W-1:0]           char_ff;
   logic [stcw_pkg::READ_LINE_W-1:0]      read_line_ff;
   logic [stcw_pkg::READ_COL_W-1:0]       read_column_ff;
   logic                                  read_hit_ff;
   logic [stcw_pkg::CHAR_W-1:0]           rdata_ff;
   logic [stcw_pkg::CHAR_W-1:0]           cell_char_ff;
   logic [stcw_pkg::CURSOR_W-1:0]         cursor_column_ff;
   logic                                  newline_pending_ff;

   logic [stcw_pkg::CHAR_W-1:0] mem [DEPTH];

   logic [stcw_pkg::CURSOR_W-1:0] width_eff;
   logic [stcw_pkg::LINES_W-1:0]  lines_eff;
   logic [stcw_pkg::ROW_W-1:0]    cur_row;
   logic [stcw_pkg::ROW_W-1:0]    top_scrolled;
   logic [stcw_pkg::LINES_W-1:0]  top_plus_one;
   logic [stcw_pkg::LINES_W-1:0]  read_sum;
   logic [stcw_pkg::ROW_W-1:0]    read_row;
   logic                          read_hit;
   logic [stcw_pkg::CURSOR_W-1:0] cursor_inc;
   logic [stcw_pkg::CURSOR_W-1:0] cursor_adv;
   logic [stcw_pkg::CURSOR_W-1:0] cursor_clamped;
   logic                          cell_in_line;
   logic                          mem_we;
   logic [stcw_pkg::ADDR_W-1:0]   mem_waddr;
   logic [stcw_pkg::CHAR_W-1:0]   mem_wdata;
   logic [stcw_pkg::ADDR_W-1:0]   mem_raddr;
   stcw_pkg::char_class_type      char_class;

   // Effective line width and region height
   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = stcw_pkg::CURSOR_W'(1);
      end else if (line_width_ff > stcw_pkg::CURSOR_W'(stcw_pkg::MAX_WIDTH)) begin
         width_eff = stcw_pkg::CURSOR_W'(stcw_pkg::MAX_WIDTH);
      end else begin
         width_eff = line_width_ff;
      end
      if (scroll_lines_ff == '0) begin
         lines_eff = stcw_pkg::LINES_W'(1);
      end else if (scroll_lines_ff > stcw_pkg::LINES_W'(stcw_pkg::MAX_LINES)) begin
         lines_eff = stcw_pkg::LINES_W'(stcw_pkg::MAX_LINES);
      end else begin
         lines_eff = scroll_lines_ff;
      end
   end

   // Ring arithmetic: current line sits just above the oldest one
   always_comb begin
      cur_row      = (top_ff == '0) ? stcw_pkg::ROW_W'(lines_eff - 1'b1) : top_ff - 1'b1;
      top_plus_one = {1'b0, top_ff} + 1'b1;
      top_scrolled = (top_plus_one == lines_eff) ? '0 : top_plus_one[stcw_pkg::ROW_W-1:0];
      read_sum     = {1'b0, top_ff} + {1'b0, read_line_ff};
      read_row     = (read_sum >= lines_eff) ? stcw_pkg::ROW_W'(read_sum - lines_eff)
                                             : read_sum[stcw_pkg::ROW_W-1:0];
      read_hit     = ({1'b0, read_line_ff} < lines_eff) &&
                     ({1'b0, read_column_ff} < width_eff) &&
                     row_valid_ff[read_row];
   end

   // Cursor arithmetic
   always_comb begin
      cursor_inc     = cursor_ff + 1'b1;
      cursor_adv     = (cursor_inc > width_eff) ? width_eff : cursor_inc;
      cursor_clamped = (cursor_ff > width_eff) ? width_eff : cursor_ff;
      cell_in_line   = (cursor_ff < width_eff);
   end

   // Character classes
   always_comb begin
      case (char_ff)
         stcw_pkg::CH_TAB:   char_class = stcw_pkg::CLS_TAB;
         stcw_pkg::CH_LF:    char_class = stcw_pkg::CLS_LF;
         stcw_pkg::CH_CR:    char_class = stcw_pkg::CLS_CR;
         stcw_pkg::CH_SPACE: char_class = stcw_pkg::CLS_SPACE;
         default:            char_class = stcw_pkg::CLS_OTHER;
      endcase
   end

   // Status to the sequencer
   always_comb begin
      status.is_read      = (command_ff == stcw_pkg::CMD_READ);
      status.char_class   = char_class;
      status.need_scroll  = pending_ff ||
                            ((char_class == stcw_pkg::CLS_OTHER) && !cell_in_line);
      status.cell_in_line = cell_in_line;
      status.row_valid    = row_valid_ff[cur_row];
      status.sweep_last   = (sweep_cnt_ff == stcw_pkg::COL_W'(stcw_pkg::MAX_WIDTH - 1));
      status.tab_last     = &cursor_ff[stcw_pkg::TAB_W-1:0];
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Next values of the control state
   always_comb begin
      line_width_in   = line_width_ff;
      scroll_lines_in = scroll_lines_ff;
      top_in          = top_ff;
      cursor_in       = cursor_ff;
      pending_in      = pending_ff;
      row_valid_in    = row_valid_ff;
      sweep_cnt_in    = sweep_cnt_ff;
      if (csr_wr_en) begin
         if (csr_index == stcw_pkg::CSR_LINE_WIDTH) begin
            line_width_in = csr_wr_data[stcw_pkg::CURSOR_W-1:0];
         end else begin
            scroll_lines_in = csr_wr_data[stcw_pkg::LINES_W-1:0];
         end
         // a new setup empties the console
         top_in       = '0;
         cursor_in    = '0;
         pending_in   = 1'b0;
         row_valid_in = '0;
      end else begin
         // scroll: oldest row is dropped and becomes the new current row
         if (cmd.scroll || (cmd.do_lf && pending_ff)) begin
            row_valid_in[top_ff] = 1'b0;
            top_in               = top_scrolled;
            cursor_in            = '0;
            pending_in           = 1'b0;
         end
         if (cmd.do_lf) begin
            pending_in = 1'b1;
         end
         if (cmd.sweep_start) begin
            sweep_cnt_in = '0;
         end
         if (cmd.sweep_step) begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (status.sweep_last) begin
               row_valid_in[cur_row] = 1'b1;
            end
         end
         if (cmd.put_char) begin
            cursor_in = cursor_adv;
         end
         if (cmd.tab_step) begin
            cursor_in = status.tab_last ? cursor_adv : cursor_inc;
         end
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= stcw_pkg::LINE_WIDTH_RESET;
         scroll_lines_ff <= stcw_pkg::SCROLL_LINES_RESET;
         top_ff          <= '0;
         cursor_ff       <= '0;
         pending_ff      <= 1'b0;
         row_valid_ff    <= '0;
         sweep_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         line_width_ff   <= line_width_in;
         scroll_lines_ff <= scroll_lines_in;
         top_ff          <= top_in;
         cursor_ff       <= cursor_in;
         pending_ff      <= pending_in;
         row_valid_ff    <= row_valid_in;
         sweep_cnt_ff    <= sweep_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Item capture and result register
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         command_ff     <= item_command;
         char_ff        <= item_char_code;
         read_line_ff   <= item_read_line;
         read_column_ff <= item_read_column;
      end
      if (cmd.mem_read) begin
         read_hit_ff <= read_hit;
      end
      if (cmd.load_rsp) begin
         cell_char_ff       <= ((command_ff == stcw_pkg::CMD_READ) && read_hit_ff) ?
                               rdata_ff : '0;
         cursor_column_ff   <= cursor_clamped;
         newline_pending_ff <= pending_ff;
      end
   end

   // Memory port select: row sweep or a cell write at the cursor
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {cur_row, cursor_ff[stcw_pkg::COL_W-1:0]};
      mem_wdata = char_ff;
      if (cmd.sweep_step) begin
         mem_we    = 1'b1;
         mem_waddr = {cur_row, sweep_cnt_ff};
         mem_wdata = '0;
      end else if ((cmd.put_char || cmd.tab_step) && cell_in_line) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.tab_step ? stcw_pkg::CH_SPACE : char_ff;
      end
      mem_raddr = {read_row, stcw_pkg::COL_W'(read_column_ff)};
   end

   // Cell memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_char       = cell_char_ff;
   assign rsp_cursor_column   = cursor_column_ff;
   assign rsp_newline_pending = newline_pending_ff;

endmodule

[hdl/scrolling_text_console_writer.sv]
// Top level of the scrolling text console: sequencer, datapath and checks.
//
// Usage: an item on req either puts one character (command 0) or reads one
// cell (command 1, read_line 0 is the oldest line). Every item yields one
// item on rsp with the cell read (0 on put or outside the region), the
// cursor column and the pending line feed flag.
// Timing: one item at a time. A read, CR or LF passes DECODE and RESULT, a
// printable character or space DECODE, CHECK, WRITE and RESULT, and a tab
// DECODE, CHECK, a TAB step per column (1 to 8 steps up to the next tab stop)
// and RESULT. Before the first write into a line emptied by a scroll, SWEEP
// zeroes that line one cell a cycle through the single memory write port.
// req is taken again in the cycle after the result is loaded.
// Reset and csr writes restore the default registers (on reset) and empty
// the console at once through per-line valid bits, with no clearing pass.
// Stall: a finished result waits in the output register until rsp.ready;
// the next item can be taken meanwhile, its result waiting for the slot.
module scrolling_text_console_writer (
   input  logic                              clock,
   input  logic                              reset,
   stcw_req_if.sink                          req,
   stcw_rsp_if.source                        rsp,
   input  logic                              csr_wr_en,
   input  logic [stcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stcw_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   stcw_pkg::cmd_type    ctrl_cmd;
   stcw_pkg::status_type dp_status;

   stcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   stcw_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctrl_cmd),
      .status              (dp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .item_command        (req.command),
      .item_char_code      (req.char_code),
      .item_read_line      (req.read_line),
      .item_read_column    (req.read_column),
      .rsp_ready           (rsp.ready),
      .rsp_valid           (rsp.valid),
      .rsp_cell_char       (rsp.cell_char),
      .rsp_cursor_column   (rsp.cursor_column),
      .rsp_newline_pending (rsp.newline_pending)
   );

   assign req.ready = ctrl_cmd.req_ready;

   // One item in flight: after an accept the sequencer is busy
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("item accepted while another is in progress");

   // The result register is only loaded when it is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_rsp |-> (!rsp.valid || rsp.ready))
      else $error("pending result overwritten");

   // Reported cursor never exceeds the widest line
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.cursor_column <= stcw_pkg::CURSOR_W'(stcw_pkg::MAX_WIDTH)))
      else $error("cursor column out of range");

endmodule
